[hdl/omap_pkg.sv]
package omap_pkg;

  localparam int ADDR_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // Function codes of a command transaction.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } omap_func_t;

  // Status codes of a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } omap_status_t;

  // One table entry: source and target address.
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] tgt;
  } omap_pair_t;

endpackage

[hdl/omap_if.sv]
interface omap_in_if
  import omap_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] from_value;
  logic [ADDR_W-1:0] to_value;
  logic [ADDR_W-1:0] query_address;

  modport source (output valid, func, from_value, to_value, query_address, input ready);
  modport sink   (input valid, func, from_value, to_value, query_address, output ready);
endinterface

interface omap_out_if
  import omap_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   mapped_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, mapped_address, status, input ready);
  modport sink   (input valid, mapped_address, status, output ready);
endinterface

[hdl/omap_search_cell.sv]
// One step of the bit-by-bit search. The cell owns the table entries whose
// position plus one has its lowest set bit at LEVEL, which are exactly the
// entries this step can ever probe.
module omap_search_cell
  import omap_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int CNT_W       = 11,
  parameter int LEVEL       = 0
) (
  input  logic              clk,
  input  logic [CNT_W-1:0]  count,
  input  logic [ADDR_W-1:0] addr,
  input  logic [CNT_W-1:0]  p_in,
  input  omap_pair_t        hit_in,
  output logic [CNT_W-1:0]  p_out,
  output omap_pair_t        hit_out,
  input  logic              wr_en,
  input  logic [CNT_W-1:0]  wr_pos,
  input  omap_pair_t        wr_pair
);

  localparam int DEPTH = (MAX_ENTRIES - (1 << LEVEL)) / (2 << LEVEL) + 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] BIT  = {{(CNT_W-1){1'b0}}, 1'b1} << LEVEL;
  localparam logic [CNT_W-1:0] MASK = (BIT << 1) - {{(CNT_W-1){1'b0}}, 1'b1};

  omap_pair_t       mem [DEPTH];
  omap_pair_t       rd_pair;
  logic [CNT_W-1:0] p_q;
  omap_pair_t       hit_q;

  logic [CNT_W-1:0] rd_full;
  logic [CNT_W-1:0] wr_full;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_here;
  logic [CNT_W-1:0] cand;
  logic             take;

  assign rd_full = p_in >> (LEVEL + 1);
  assign wr_full = wr_pos >> (LEVEL + 1);
  assign rd_idx  = rd_full[IDX_W-1:0];
  assign wr_idx  = wr_full[IDX_W-1:0];
  assign wr_here = wr_en && ((wr_pos & MASK) == BIT);

  always_ff @(posedge clk) begin
    if (wr_here) begin
      mem[wr_idx] <= wr_pair;
    end
    rd_pair <= mem[rd_idx];
    p_q     <= p_in;
    hit_q   <= hit_in;
  end

  // Extend the prefix when the probed entry exists and is not above addr.
  assign cand    = p_q | BIT;
  assign take    = (cand <= count) && (rd_pair.src <= addr);
  assign p_out   = take ? cand : p_q;
  assign hit_out = take ? rd_pair : hit_q;

endmodule

[hdl/omap_address_remap_table.sv]
// Address remap table. Holds up to MAX_ENTRIES (from, to) pairs in append
// order, from values non-decreasing. Each command transaction yields exactly
// one result transaction. Clear empties the table; append adds a pair at the
// end and reports table full or out of order when it cannot; query finds the
// last entry whose from is not above the address and returns
// to + (address - from) modulo 2^32, zero for an unmapped entry (to of zero),
// or status "no covering entry". The table is spread over a row of
// CNT_W = clog2(MAX_ENTRIES+1) search cells, one per bit of the entry count;
// each cell owns the entries that its bit of the search can probe and has
// its own memory. A query walks down the row one cell per cycle; clear,
// append and unused codes skip the search and pass to the hold state.
// One command is worked on at a time; the next command is taken as soon
// as the result sits in the output register, even if the sink has not
// yet taken it. No clearing pass after reset: entries are only read below
// the entry count.
module omap_address_remap_table
  import omap_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  omap_in_if.sink    cmd,
  omap_out_if.source res
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int STEP_W = $clog2(CNT_W);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0]  CNT_ONE  = {{(CNT_W-1){1'b0}}, 1'b1};
  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(CNT_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_HOLD} state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  entry_count;
  logic [ADDR_W-1:0] last_from;
  logic [ADDR_W-1:0] query_addr;
  logic [ADDR_W-1:0] pend_addr;
  omap_status_t      pend_status;
  logic              res_valid;
  logic [ADDR_W-1:0] res_addr;
  omap_status_t      res_status;

  logic              cmd_acc;
  logic              out_free;
  logic              app_ok;
  logic [CNT_W-1:0]  wr_pos;
  omap_pair_t        wr_pair;
  logic [CNT_W-1:0]  p_link   [0:CNT_W];
  omap_pair_t        hit_link [0:CNT_W];
  logic              found;
  logic [ADDR_W-1:0] hit_result;

  assign cmd.ready          = (state == S_IDLE);
  assign cmd_acc            = cmd.valid && cmd.ready;
  assign out_free           = !res_valid || res.ready;
  assign res.valid          = res_valid;
  assign res.mapped_address = res_addr;
  assign res.status         = res_status;

  // Append goes to position entry_count; cells locate it by entry_count + 1.
  assign app_ok = (entry_count != CNT_MAX) &&
                  ((entry_count == '0) || (cmd.from_value >= last_from));
  assign wr_pos      = entry_count + CNT_ONE;
  assign wr_pair.src = cmd.from_value;
  assign wr_pair.tgt = cmd.to_value;

  // The top cell starts from an empty prefix.
  assign p_link[CNT_W]   = '0;
  assign hit_link[CNT_W] = '0;

  for (genvar g = 0; g < CNT_W; g++) begin : g_cell
    omap_search_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CNT_W       (CNT_W),
      .LEVEL       (g)
    ) u_cell (
      .clk     (clk),
      .count   (entry_count),
      .addr    (query_addr),
      .p_in    (p_link[g+1]),
      .hit_in  (hit_link[g+1]),
      .p_out   (p_link[g]),
      .hit_out (hit_link[g]),
      .wr_en   (cmd_acc && (cmd.func == FUNC_APPEND) && app_ok),
      .wr_pos  (wr_pos),
      .wr_pair (wr_pair)
    );
  end

  // The bottom cell's prefix is the number of entries not above the address.
  assign found      = (p_link[0] != '0);
  assign hit_result = hit_link[0].tgt + (query_addr - hit_link[0].src);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      // Drop the taken result, unless a new one moves in this cycle.
      if (res_valid && res.ready && (state != S_HOLD)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            pend_addr <= '0;
            unique case (omap_func_t'(cmd.func))
              FUNC_CLEAR: begin
                entry_count <= '0;
                pend_status <= ST_OK;
                state       <= S_HOLD;
              end
              FUNC_APPEND: begin
                state <= S_HOLD;
                if (entry_count == CNT_MAX) begin
                  pend_status <= ST_FULL;
                end else if (!app_ok) begin
                  pend_status <= ST_ORDER;
                end else begin
                  pend_status <= ST_OK;
                  entry_count <= wr_pos;
                  last_from   <= cmd.from_value;
                end
              end
              FUNC_QUERY: begin
                query_addr <= cmd.query_address;
                step       <= STEP_TOP;
                state      <= S_SEARCH;
              end
              default: begin
                // Unused code: answer ok, change nothing.
                pend_status <= ST_OK;
                state       <= S_HOLD;
              end
            endcase
          end
        end
        S_SEARCH: begin
          // Advance until the answer has rippled through every cell.
          if (step == '0) begin
            if (!found) begin
              pend_addr   <= '0;
              pend_status <= ST_MISS;
            end else begin
              pend_addr   <= (hit_link[0].tgt == '0) ? '0 : hit_result;
              pend_status <= ST_OK;
            end
            state <= S_HOLD;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        S_HOLD: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            res_valid  <= 1'b1;
            res_addr   <= pend_addr;
            res_status <= pend_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_MAX)
    else $error("entry count above table size");

  a_count_still: assert property (@(posedge clk) disable iff (rst)
    !cmd_acc |=> $stable(entry_count))
    else $error("entry count changed without a transaction");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) && (step == '0) |=> (state == S_HOLD))
    else $error("search did not finish on time");

  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != ST_OK) |-> (res_addr == '0))
    else $error("failed result carries an address");

endmodule
